FILE: sv/utf_pkg.sv
// ----------------------------------------------------------------------------
// utf_pkg: shared types and constants for the UTF-16 to UTF-8 encoder
// Holds the code unit entry passed between front and back, the byte
// constants and the encoding function.
// ----------------------------------------------------------------------------
package utf_pkg;

   localparam logic [7:0] BOM_FIRST  = 8'hFF;
   localparam logic [7:0] BOM_SECOND = 8'hFE;
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [15:0] MAX_ONE   = 16'h007F;
   localparam logic [15:0] MAX_TWO   = 16'h07FF;

   // Byte counts of an encoded code unit.
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   // CSR map
   localparam logic REG_NUL_AS_TWO_BYTES = 1'b0;

   typedef struct packed {
      logic [2:0][7:0] bytes;   // bytes[0] goes out first
      logic [1:0]      count;   // 1 to 3
   } unit_entry_type;

   function automatic unit_entry_type encode_unit(input logic [15:0] unit,
                                                  input logic       nul_two);
      unit_entry_type e;
      e.bytes = '0;
      e.count = CNT_ONE;
      if (unit == 16'h0000) begin
         if (nul_two) begin
            e.bytes[0] = LEAD_TWO;
            e.bytes[1] = CONT_MARK;
            e.count    = CNT_TWO;
         end
      end else if (unit <= MAX_ONE) begin
         e.bytes[0] = unit[7:0];
      end else if (unit <= MAX_TWO) begin
         e.bytes[0] = LEAD_TWO | {3'b000, unit[10:6]};
         e.bytes[1] = CONT_MARK | {2'b00, unit[5:0]};
         e.count    = CNT_TWO;
      end else begin
         e.bytes[0] = LEAD_THREE | {4'b0000, unit[15:12]};
         e.bytes[1] = CONT_MARK | {2'b00, unit[11:6]};
         e.bytes[2] = CONT_MARK | {2'b00, unit[5:0]};
         e.count    = CNT_THREE;
      end
      return e;
   endfunction

endpackage

FILE: sv/utf_front.sv
// ----------------------------------------------------------------------------
// utf_front: byte pairing, byte order detection and unit encoding
// Pairs input bytes into 16-bit units, drops a leading FF FE mark and
// writes each encoded unit into the queue.
// ----------------------------------------------------------------------------
module utf_front import utf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     in_byte,
   input  logic           stream_start,
   input  logic           nul_two,
   output logic           wr_en,
   output unit_entry_type wr_data
);

   logic [7:0] held_byte_ff, held_byte_in;
   logic       have_half_ff, have_half_in;
   logic       lsb_first_ff, lsb_first_in;
   logic       first_pair_ff, first_pair_in;

   logic       have_eff, le_eff, first_eff, is_bom;
   logic [15:0] unit;

   always_comb begin
      // stream start clears pairing state before the byte is taken
      have_eff  = have_half_ff & ~stream_start;
      le_eff    = lsb_first_ff & ~stream_start;
      first_eff = first_pair_ff | stream_start;
      is_bom    = (held_byte_ff == BOM_FIRST) && (in_byte == BOM_SECOND);

      held_byte_in  = held_byte_ff;
      have_half_in  = have_eff;
      lsb_first_in  = le_eff;
      first_pair_in = first_eff;
      wr_en         = 1'b0;

      if (!have_eff) begin
         held_byte_in = in_byte;
         have_half_in = 1'b1;
      end else begin
         have_half_in = 1'b0;
         if (first_eff) begin
            first_pair_in = 1'b0;
            lsb_first_in  = is_bom;
            wr_en         = accept & ~is_bom;
         end else begin
            wr_en = accept;
         end
      end

      // first pair that is not a mark is always big-endian
      if (le_eff && !first_eff) begin
         unit = {in_byte, held_byte_ff};
      end else begin
         unit = {held_byte_ff, in_byte};
      end
      wr_data = encode_unit(unit, nul_two);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_half_ff  <= 1'b0;
         lsb_first_ff  <= 1'b0;
         first_pair_ff <= 1'b1;
         held_byte_ff  <= '0;
      end else if (accept) begin
         have_half_ff  <= have_half_in;
         lsb_first_ff  <= lsb_first_in;
         first_pair_ff <= first_pair_in;
         held_byte_ff  <= held_byte_in;
      end
   end

endmodule

FILE: sv/utf_queue.sv
// ----------------------------------------------------------------------------
// utf_queue: small register queue of encoded units
// Decouples the pairing front from the byte emitter.
// ----------------------------------------------------------------------------
module utf_queue import utf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  unit_entry_type wr_data,
   output logic           full,
   input  logic           rd_en,
   output unit_entry_type rd_data,
   output logic           empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   unit_entry_type   slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   always_comb begin
      full    = (count_ff == FULL_CNT);
      empty   = (count_ff == '0);
      do_wr   = wr_en & ~full;
      do_rd   = rd_en & ~empty;
      rd_data = slots_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/utf_back.sv
// ----------------------------------------------------------------------------
// utf_back: byte emitter
// Walks the bytes of the queue head, one per cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module utf_back import utf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  unit_entry_type head,
   input  logic           head_empty,
   output logic           head_pop,
   input  logic           pop,
   output logic           empty,
   output logic [7:0]     out_byte,
   output logic           last_of_char
);

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load, is_last;

   always_comb begin
      load     = ~head_empty & (~out_valid_ff | pop);
      is_last  = (idx_ff == head.count - 2'd1);
      head_pop = load & is_last;
      idx_in   = idx_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= head.bytes[idx_ff];
         out_last_ff <= is_last;
      end
   end

   assign empty        = ~out_valid_ff;
   assign out_byte     = out_byte_ff;
   assign last_of_char = out_last_ff;

endmodule

FILE: sv/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder: UTF-16 byte stream to UTF-8 byte stream
// Pairs bytes into code units (FF FE at stream start selects little-endian)
// and emits each unit as 1 to 3 UTF-8 bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake         Payload
//  -------   ---------  ----------------  ----------------------------------
//  req       in         push / full       req_in_byte, req_stream_start
//  rsp       out        empty / pop       rsp_out_byte, rsp_last_of_char
//  csr       in/out     APB, pready = 1   bit 0 at 0x0: nul_as_two_bytes
//
//  An input byte is taken whenever the queue has room; the encoded unit
//  lands in the queue at the edge that takes its second byte, so the front
//  hands over at most one unit for every two input bytes.
//  The back emits one UTF-8 byte per cycle while the output is not stalled,
//  and each unit yields 1 to 3 bytes, so for three-byte text the emitter
//  sets the sustained input rate.
//  empty falls at the clock edge after the edge that takes the byte which
//  completes a unit.
//  Reset (synchronous) empties the queue and output register, selects
//  big-endian and arms the byte order mark check; no clearing pass.
//  full rises only while the queue holds QUEUE_DEPTH units; a stalled
//  output keeps accepting bytes until then.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder import utf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_start,
   // result items
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_char,
   // control registers
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic           nul_two_ff;
   logic           accept;
   logic           wr_en, q_full, q_empty, q_pop;
   unit_entry_type wr_data, head;

   // CSR: single register decoded on paddr[2] only; 0x4 to 0x7 read zero and ignore writes
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         nul_two_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready
                   && (paddr[2] == REG_NUL_AS_TWO_BYTES)) begin
         nul_two_ff <= pwdata[0];
      end
   end
   assign prdata = (paddr[2] == REG_NUL_AS_TWO_BYTES) ? {31'd0, nul_two_ff} : 32'd0;

   // front takes a byte whenever the queue has room
   assign full   = q_full;
   assign accept = push & ~q_full;

   utf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .stream_start (req_stream_start),
      .nul_two      (nul_two_ff),
      .wr_en        (wr_en),
      .wr_data      (wr_data)
   );

   utf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   utf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_empty   (q_empty),
      .head_pop     (q_pop),
      .pop          (pop),
      .empty        (empty),
      .out_byte     (rsp_out_byte),
      .last_of_char (rsp_last_of_char)
   );

endmodule

FILE: sv/utf_checker.sv
// ----------------------------------------------------------------------------
// utf_checker: port-level checks for the UTF-16 to UTF-8 encoder
// Watches the top-level ports and flags malformed output or bad reset.
// ----------------------------------------------------------------------------
module utf_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_char
);

   // reset leaves no item waiting at the output
   assert property (@(posedge clock) reset |=> empty)
      else $error("output not empty after reset");

   // reset leaves room for input
   assert property (@(posedge clock) reset |=> !full)
      else $error("full after reset");

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte)
                            && $stable(rsp_last_of_char)))
      else $error("stalled item changed");

   // a non-final byte of a unit is a lead or continuation byte, never ASCII
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_last_of_char) |-> (rsp_out_byte[7] == 1'b1))
      else $error("non-final byte is ASCII");

   // a final byte is ASCII or a continuation byte
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_char)
         |-> (rsp_out_byte[7] == 1'b0 || rsp_out_byte[7:6] == 2'b10))
      else $error("final byte is a lead byte");

endmodule

bind utf16_to_utf8_encoder utf_checker u_utf_checker (
   .clock            (clock),
   .reset            (reset),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_last_of_char (rsp_last_of_char)
);
